### hdl/battery_filter_throttle_limiter_macros.svh
// Assertion macros shared by the battery filter and throttle limiter RTL.
`ifndef BATTERY_FILTER_THROTTLE_LIMITER_MACROS_SVH
`define BATTERY_FILTER_THROTTLE_LIMITER_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define BFTL_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("bftl assertion failed");

// Next-cycle implication under an active-low reset.
`define BFTL_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bftl assertion failed");

`endif

### hdl/bftl_pkg.sv
// Types, constants and microcode ROM for the battery filter and throttle limiter.
package bftl_pkg;

    localparam int VOLT_W     = 20;
    localparam int SCALE_W    = 24;
    localparam int CELLV_W    = 16;
    localparam int THR_W      = 16;
    localparam int ADC_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int PRIME_W    = 8;
    localparam int MUL_W      = 24;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ACC_W      = 28;
    localparam int DIV_NUM_W  = 33;
    localparam int DIV_DEN_W  = 16;

    // Filter weights and divisor
    localparam int FILTER_DIV = 16;
    localparam int OLD_WEIGHT = 15;
    localparam int NEW_WEIGHT = 1;

    localparam logic [VOLT_W-1:0] VOLT_MAX = 20'hFFFFF;

    // Reset values
    localparam logic [SCALE_W-1:0] VOLT_SCALE_RST  = 24'd4803000;
    localparam logic [VOLT_W-1:0]  THREE_FLOOR_RST = 20'd88000;
    localparam logic [VOLT_W-1:0]  TWO_FLOOR_RST   = 20'd44000;
    localparam logic [CELLV_W-1:0] CUTOFF_RST      = 16'd30000;
    localparam logic [CELLV_W-1:0] LOW_MARK_RST    = 16'd33000;
    localparam logic [VOLT_W-1:0]  FILTERED_RST    = 20'd84000;

    localparam logic [1:0] CELLS_ONE   = 2'd1;
    localparam logic [1:0] CELLS_TWO   = 2'd2;
    localparam logic [1:0] CELLS_THREE = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VOLT_SCALE  = 3'd0,
        REG_THREE_FLOOR = 3'd1,
        REG_TWO_FLOOR   = 3'd2,
        REG_CELL_CUTOFF = 3'd3,
        REG_CELL_LOW    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic                    command;
        logic [ADC_W-1:0]        adc_sample;
        logic signed [THR_W-1:0] throttle_demand;
        logic                    stick_high;
        logic signed [THR_W-1:0] throttle_floor;
    } in_item_t;

    typedef struct packed {
        logic signed [THR_W-1:0] throttle_out;
        logic [VOLT_W-1:0]       pack_voltage;
        logic [1:0]              cell_count;
        logic                    cells_known;
    } out_item_t;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
    } div_sts_t;

    // Datapath operations, one per control word
    typedef enum logic [4:0] {
        OP_NOP,
        OP_MUL_RAW,
        OP_MUL_OLD,
        OP_MUL_NEW,
        OP_DIV_ACC,
        OP_FILTER,
        OP_LATCH,
        OP_DIV_CELL,
        OP_CELL,
        OP_COMPARE,
        OP_ABS,
        OP_MUL_SCALE,
        OP_DIV_SCALE,
        OP_SCALED,
        OP_FLOOR,
        OP_DEMAND,
        OP_DONE
    } op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_CMD,
        C_DIV_BUSY,
        C_BELOW_CUT,
        C_NO_SCALE,
        C_OUT_FULL
    } cond_t;

    localparam int STEP_W = 5;

    localparam logic [STEP_W-1:0] UPC_DISPATCH   = 5'd0;
    localparam logic [STEP_W-1:0] UPC_MUL_RAW    = 5'd1;
    localparam logic [STEP_W-1:0] UPC_MUL_OLD    = 5'd2;
    localparam logic [STEP_W-1:0] UPC_MUL_NEW    = 5'd3;
    localparam logic [STEP_W-1:0] UPC_DIV_ACC    = 5'd4;
    localparam logic [STEP_W-1:0] UPC_WAIT_ACC   = 5'd5;
    localparam logic [STEP_W-1:0] UPC_FILTER     = 5'd6;
    localparam logic [STEP_W-1:0] UPC_LATCH      = 5'd7;
    localparam logic [STEP_W-1:0] UPC_THROTTLE   = 5'd8;
    localparam logic [STEP_W-1:0] UPC_WAIT_CELL  = 5'd9;
    localparam logic [STEP_W-1:0] UPC_CELL       = 5'd10;
    localparam logic [STEP_W-1:0] UPC_COMPARE    = 5'd11;
    localparam logic [STEP_W-1:0] UPC_ABS        = 5'd12;
    localparam logic [STEP_W-1:0] UPC_CHECK      = 5'd13;
    localparam logic [STEP_W-1:0] UPC_MUL_SCALE  = 5'd14;
    localparam logic [STEP_W-1:0] UPC_DIV_SCALE  = 5'd15;
    localparam logic [STEP_W-1:0] UPC_WAIT_SCALE = 5'd16;
    localparam logic [STEP_W-1:0] UPC_SCALED     = 5'd17;
    localparam logic [STEP_W-1:0] UPC_FLOOR      = 5'd18;
    localparam logic [STEP_W-1:0] UPC_DEMAND     = 5'd19;
    localparam logic [STEP_W-1:0] UPC_DONE       = 5'd20;

    typedef struct packed {
        op_t               op;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } uword_t;

    function automatic uword_t ucode(input logic [STEP_W-1:0] upc);
        uword_t w;
        w = '{OP_NOP, C_NEVER, UPC_DISPATCH};
        case (upc)
            UPC_DISPATCH:   w = '{OP_NOP,       C_CMD,       UPC_THROTTLE};
            UPC_MUL_RAW:    w = '{OP_MUL_RAW,   C_NEVER,     UPC_DISPATCH};
            UPC_MUL_OLD:    w = '{OP_MUL_OLD,   C_NEVER,     UPC_DISPATCH};
            UPC_MUL_NEW:    w = '{OP_MUL_NEW,   C_NEVER,     UPC_DISPATCH};
            UPC_DIV_ACC:    w = '{OP_DIV_ACC,   C_NEVER,     UPC_DISPATCH};
            UPC_WAIT_ACC:   w = '{OP_NOP,       C_NEVER,     UPC_DISPATCH};
            UPC_FILTER:     w = '{OP_FILTER,    C_NEVER,     UPC_DISPATCH};
            UPC_LATCH:      w = '{OP_LATCH,     C_ALWAYS,    UPC_DONE};
            UPC_THROTTLE:   w = '{OP_DIV_CELL,  C_NEVER,     UPC_DISPATCH};
            UPC_WAIT_CELL:  w = '{OP_NOP,       C_DIV_BUSY,  UPC_WAIT_CELL};
            UPC_CELL:       w = '{OP_CELL,      C_NEVER,     UPC_DISPATCH};
            UPC_COMPARE:    w = '{OP_COMPARE,   C_NEVER,     UPC_DISPATCH};
            UPC_ABS:        w = '{OP_ABS,       C_BELOW_CUT, UPC_FLOOR};
            UPC_CHECK:      w = '{OP_NOP,       C_NO_SCALE,  UPC_DEMAND};
            UPC_MUL_SCALE:  w = '{OP_MUL_SCALE, C_NEVER,     UPC_DISPATCH};
            UPC_DIV_SCALE:  w = '{OP_DIV_SCALE, C_NEVER,     UPC_DISPATCH};
            UPC_WAIT_SCALE: w = '{OP_NOP,       C_DIV_BUSY,  UPC_WAIT_SCALE};
            UPC_SCALED:     w = '{OP_SCALED,    C_ALWAYS,    UPC_DONE};
            UPC_FLOOR:      w = '{OP_FLOOR,     C_ALWAYS,    UPC_DONE};
            UPC_DEMAND:     w = '{OP_DEMAND,    C_NEVER,     UPC_DISPATCH};
            UPC_DONE:       w = '{OP_DONE,      C_OUT_FULL,  UPC_DONE};
            default:        w = '{OP_NOP,       C_NEVER,     UPC_DISPATCH};
        endcase
        return w;
    endfunction

endpackage

### hdl/battery_filter_throttle_limiter.sv
// Battery voltage filter, cell-count detector and throttle limiter, microcoded.
// A sample word updates the filter; a throttle request gives the floor (cutoff),
// the demand (pass-through) or a scaled-down throttle.
// The next word is taken the cycle after a result is loaded, one word at a time.
// The 33-step restoring divider is shared by the cell-voltage and scaling divisions.
// Reset (async, active low) restores the registers and filter state at once.
`include "battery_filter_throttle_limiter_macros.svh"

module battery_filter_throttle_limiter (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  bftl_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output bftl_pkg::out_item_t                out_data,
    input  logic                               cfg_wen,
    input  logic [bftl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bftl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int VOLT_W  = bftl_pkg::VOLT_W;
    localparam int CELLV_W = bftl_pkg::CELLV_W;
    localparam int THR_W   = bftl_pkg::THR_W;
    localparam int PROD_W  = bftl_pkg::PROD_W;
    localparam int MUL_W   = bftl_pkg::MUL_W;
    localparam int ACC_W   = bftl_pkg::ACC_W;
    localparam int NUM_W   = bftl_pkg::DIV_NUM_W;
    localparam int DEN_W   = bftl_pkg::DIV_DEN_W;
    localparam int STEP_W  = bftl_pkg::STEP_W;
    localparam int PRIME_W = bftl_pkg::PRIME_W;

    // Configuration
    logic [bftl_pkg::SCALE_W-1:0] volt_scale_reg;
    logic [VOLT_W-1:0]            three_floor_reg;
    logic [VOLT_W-1:0]            two_floor_reg;
    logic [CELLV_W-1:0]           cutoff_reg;
    logic [CELLV_W-1:0]           low_mark_reg;

    // Filter state
    logic [VOLT_W-1:0]  fv_reg;
    logic [PRIME_W-1:0] prime_reg;
    logic [PRIME_W-1:0] prime_next;
    logic [1:0]         cells_reg;
    logic               latched_reg;

    // Sequencer
    logic               busy_reg;
    logic [STEP_W-1:0]  upc_reg;
    logic [STEP_W-1:0]  upc_next;
    bftl_pkg::uword_t   uword;
    bftl_pkg::op_t      op;
    logic               taken;
    logic               out_full;
    logic               fire_done;

    // Datapath
    bftl_pkg::in_item_t item_reg;
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [PROD_W-1:0]  prod_reg;
    logic [VOLT_W-1:0]  raw_reg;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   avg;
    logic [VOLT_W-1:0]  cell_reg;
    logic               below_reg;
    logic               noscale_reg;
    logic [CELLV_W-1:0] off_reg;
    logic [CELLV_W-1:0] range_reg;
    logic [THR_W:0]     dif_reg;
    logic [THR_W:0]     mag_reg;
    logic               neg_reg;
    logic [THR_W-1:0]   res_reg;
    logic [THR_W:0]     sq;

    bftl_pkg::div_ctl_t div_ctl;
    bftl_pkg::div_sts_t div_sts;
    logic [NUM_W-1:0]   div_numer;
    logic [DEN_W-1:0]   div_denom;
    logic [NUM_W-1:0]   div_quot;

    logic                out_valid_reg;
    bftl_pkg::out_item_t out_reg;

    assign in_ready  = !busy_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign uword     = bftl_pkg::ucode(upc_reg);
    assign op        = busy_reg ? uword.op : bftl_pkg::OP_NOP;
    assign out_full  = out_valid_reg && !out_ready;
    assign fire_done = (op == bftl_pkg::OP_DONE) && !out_full;

    always_comb
    begin
        unique case (uword.cond)
            bftl_pkg::C_NEVER:     taken = 1'b0;
            bftl_pkg::C_ALWAYS:    taken = 1'b1;
            bftl_pkg::C_CMD:       taken = item_reg.command;
            bftl_pkg::C_DIV_BUSY:  taken = div_sts.busy;
            bftl_pkg::C_BELOW_CUT: taken = below_reg;
            bftl_pkg::C_NO_SCALE:  taken = noscale_reg;
            bftl_pkg::C_OUT_FULL:  taken = out_full;
            default:               taken = 1'b0;
        endcase
        upc_next = taken ? uword.target : upc_reg + STEP_W'(1);
    end

    // Shared multiplier operand select
    always_comb
    begin
        unique case (op)
            bftl_pkg::OP_MUL_RAW:
            begin
                mul_a = MUL_W'(item_reg.adc_sample);
                mul_b = volt_scale_reg;
            end
            bftl_pkg::OP_MUL_OLD:
            begin
                mul_a = MUL_W'(fv_reg);
                mul_b = MUL_W'(bftl_pkg::OLD_WEIGHT);
            end
            bftl_pkg::OP_MUL_NEW:
            begin
                mul_a = MUL_W'(raw_reg);
                mul_b = MUL_W'(bftl_pkg::NEW_WEIGHT);
            end
            bftl_pkg::OP_MUL_SCALE:
            begin
                mul_a = MUL_W'(off_reg);
                mul_b = MUL_W'(mag_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Shared divider operand select
    always_comb
    begin
        div_ctl.start = 1'b0;
        div_numer     = '0;
        div_denom     = '0;
        unique case (op)
            bftl_pkg::OP_DIV_CELL:
            begin
                div_ctl.start = 1'b1;
                div_numer     = NUM_W'(fv_reg);
                div_denom     = DEN_W'(cells_reg);
            end
            bftl_pkg::OP_DIV_SCALE:
            begin
                div_ctl.start = 1'b1;
                div_numer     = prod_reg[NUM_W-1:0];
                div_denom     = range_reg;
            end
            default:
            begin
                div_ctl.start = 1'b0;
            end
        endcase
    end

    bftl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .numer (div_numer),
        .denom (div_denom),
        .sts   (div_sts),
        .quot  (div_quot)
    );

    assign prime_next = (prime_reg < PRIME_W'(bftl_pkg::FILTER_DIV))
                        ? prime_reg + PRIME_W'(1) : prime_reg;

    // Filter divisor is a power of two: a plain shift
    assign avg = acc_reg / ACC_W'(bftl_pkg::FILTER_DIV);

    // Signed quotient, truncated toward zero
    assign sq = neg_reg ? ((THR_W + 1)'(0) - div_quot[THR_W:0]) : div_quot[THR_W:0];

    // Control and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volt_scale_reg  <= bftl_pkg::VOLT_SCALE_RST;
            three_floor_reg <= bftl_pkg::THREE_FLOOR_RST;
            two_floor_reg   <= bftl_pkg::TWO_FLOOR_RST;
            cutoff_reg      <= bftl_pkg::CUTOFF_RST;
            low_mark_reg    <= bftl_pkg::LOW_MARK_RST;
            fv_reg          <= bftl_pkg::FILTERED_RST;
            prime_reg       <= '0;
            cells_reg       <= bftl_pkg::CELLS_ONE;
            latched_reg     <= 1'b0;
            busy_reg        <= 1'b0;
            upc_reg         <= bftl_pkg::UPC_DISPATCH;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                unique case (bftl_pkg::cfg_reg_t'(cfg_index))
                    bftl_pkg::REG_VOLT_SCALE:  volt_scale_reg  <= cfg_data;
                    bftl_pkg::REG_THREE_FLOOR: three_floor_reg <= cfg_data[VOLT_W-1:0];
                    bftl_pkg::REG_TWO_FLOOR:   two_floor_reg   <= cfg_data[VOLT_W-1:0];
                    bftl_pkg::REG_CELL_CUTOFF: cutoff_reg      <= cfg_data[CELLV_W-1:0];
                    bftl_pkg::REG_CELL_LOW:    low_mark_reg    <= cfg_data[CELLV_W-1:0];
                    default:                   ;
                endcase
            end

            if (op == bftl_pkg::OP_FILTER)
            begin
                // saturate the averaged voltage
                fv_reg <= (|avg[ACC_W-1:VOLT_W]) ? bftl_pkg::VOLT_MAX : avg[VOLT_W-1:0];
            end

            if ((op == bftl_pkg::OP_LATCH) && !latched_reg)
            begin
                prime_reg <= prime_next;
                if (prime_next >= PRIME_W'(bftl_pkg::FILTER_DIV))
                begin
                    latched_reg <= 1'b1;
                    if (fv_reg > three_floor_reg)
                    begin
                        cells_reg <= bftl_pkg::CELLS_THREE;
                    end
                    else if (fv_reg > two_floor_reg)
                    begin
                        cells_reg <= bftl_pkg::CELLS_TWO;
                    end
                    else
                    begin
                        cells_reg <= bftl_pkg::CELLS_ONE;
                    end
                end
            end

            if (in_valid && !busy_reg)
            begin
                busy_reg <= 1'b1;
                upc_reg  <= bftl_pkg::UPC_DISPATCH;
            end
            else if (fire_done)
            begin
                busy_reg <= 1'b0;
                upc_reg  <= bftl_pkg::UPC_DISPATCH;
            end
            else if (busy_reg)
            begin
                upc_reg <= upc_next;
            end

            if (fire_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath payload
    always_ff @(posedge clk)
    begin
        if (in_valid && !busy_reg)
        begin
            item_reg <= in_data;
        end

        unique case (op)
            bftl_pkg::OP_MUL_RAW:
            begin
                prod_reg <= mul_a * mul_b;
            end
            bftl_pkg::OP_MUL_OLD:
            begin
                raw_reg  <= prod_reg[VOLT_W+15:16];
                prod_reg <= mul_a * mul_b;
            end
            bftl_pkg::OP_MUL_NEW:
            begin
                acc_reg  <= prod_reg[ACC_W-1:0];
                prod_reg <= mul_a * mul_b;
            end
            bftl_pkg::OP_DIV_ACC:
            begin
                acc_reg <= acc_reg + prod_reg[ACC_W-1:0];
            end
            bftl_pkg::OP_MUL_SCALE:
            begin
                prod_reg <= mul_a * mul_b;
            end
            bftl_pkg::OP_CELL:
            begin
                cell_reg <= div_quot[VOLT_W-1:0];
            end
            bftl_pkg::OP_COMPARE:
            begin
                below_reg   <= VOLT_W'(cutoff_reg) > cell_reg;
                noscale_reg <= !((VOLT_W'(low_mark_reg) > cell_reg) && item_reg.stick_high);
                off_reg     <= cell_reg[CELLV_W-1:0] - cutoff_reg;
                range_reg   <= low_mark_reg - cutoff_reg;
                dif_reg     <= {item_reg.throttle_demand[THR_W-1], item_reg.throttle_demand}
                             - {item_reg.throttle_floor[THR_W-1], item_reg.throttle_floor};
            end
            bftl_pkg::OP_ABS:
            begin
                neg_reg <= dif_reg[THR_W];
                mag_reg <= dif_reg[THR_W] ? ((THR_W + 1)'(0) - dif_reg) : dif_reg;
            end
            bftl_pkg::OP_SCALED:
            begin
                res_reg <= item_reg.throttle_floor + sq[THR_W-1:0];
            end
            bftl_pkg::OP_FLOOR:
            begin
                res_reg <= item_reg.throttle_floor;
            end
            bftl_pkg::OP_DEMAND:
            begin
                res_reg <= item_reg.throttle_demand;
            end
            default:
            begin
            end
        endcase

        if (fire_done)
        begin
            out_reg.throttle_out <= item_reg.command ? res_reg : '0;
            out_reg.pack_voltage <= fv_reg;
            out_reg.cell_count   <= cells_reg;
            out_reg.cells_known  <= latched_reg;
        end
    end

    `BFTL_ASSERT_NXT(a_accept_starts, clk, rst_n, in_valid && in_ready, busy_reg)
    `BFTL_ASSERT_IMP(a_div_idle, clk, rst_n, !busy_reg, !div_sts.busy)
    `BFTL_ASSERT_NXT(a_latch_holds, clk, rst_n, latched_reg, latched_reg && $stable(cells_reg))
    `BFTL_ASSERT_IMP(a_prime_bound, clk, rst_n, 1'b1, prime_reg <= PRIME_W'(bftl_pkg::FILTER_DIV) && cells_reg != 2'd0)

endmodule

### hdl/bftl_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module bftl_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  bftl_pkg::div_ctl_t               ctl,
    input  logic [bftl_pkg::DIV_NUM_W-1:0]   numer,
    input  logic [bftl_pkg::DIV_DEN_W-1:0]   denom,
    output bftl_pkg::div_sts_t               sts,
    output logic [bftl_pkg::DIV_NUM_W-1:0]   quot
);

    localparam int NUM_W = bftl_pkg::DIV_NUM_W;
    localparam int DEN_W = bftl_pkg::DIV_DEN_W;
    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   trial;

    always_comb
    begin
        rem_sh = {rem_reg, quo_reg[NUM_W-1]};
        trial  = rem_sh - {1'b0, den_reg};
        if (!trial[DEN_W])
        begin
            rem_next = trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= '0;
            quo_reg <= numer;
            den_reg <= denom;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign sts.busy = busy_reg;
    assign quot     = quo_reg;

endmodule

### tb/sv/tb.sv
// Testbench for the battery filter, cell-count detector and throttle limiter.
`timescale 1ns / 1ps

module tb;

    localparam int THR_W      = bftl_pkg::THR_W;
    localparam int CELLV_W    = bftl_pkg::CELLV_W;
    localparam int VOLT_W     = bftl_pkg::VOLT_W;
    localparam int SCALE_W    = bftl_pkg::SCALE_W;
    localparam int ADC_W      = bftl_pkg::ADC_W;
    localparam int CFG_IDX_W  = bftl_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = bftl_pkg::CFG_DATA_W;

    localparam logic CMD_SAMPLE   = 1'b0;
    localparam logic CMD_THROTTLE = 1'b1;
    localparam int   SETTLE_CYCLES = 100;
    localparam int   PHASES        = 12;
    localparam logic signed [THR_W-1:0] THR_MAX = 16'sh7FFF;
    localparam logic signed [THR_W-1:0] THR_MIN = 16'sh8000;
    localparam int   CELLV_MAX = 65535;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    bftl_pkg::in_item_t    in_data;
    logic                  out_valid;
    logic                  out_ready;
    bftl_pkg::out_item_t   out_data;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor copy of registers and filter state
    logic [SCALE_W-1:0] p_scale;
    logic [VOLT_W-1:0]  p_three_floor;
    logic [VOLT_W-1:0]  p_two_floor;
    logic [CELLV_W-1:0] p_cutoff;
    logic [CELLV_W-1:0] p_low_mark;
    logic [VOLT_W-1:0]  p_pack;
    int                 p_primed;
    logic [1:0]         p_cells;
    logic               p_known;

    bftl_pkg::out_item_t pending_readings[$];
    int        mismatch_count;
    int        words_sent;
    int        readings_checked;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        stall_request;

    battery_filter_throttle_limiter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Advance the filter or limit the throttle, returning the reading the block should give
    function automatic bftl_pkg::out_item_t expected_reading(input bftl_pkg::in_item_t w);
        bftl_pkg::out_item_t o;
        logic [35:0] prod;
        longint acc;
        longint cellv;
        longint lo;
        longint hi;
        longint dem;
        longint flr;
        longint r;
        o = '0;
        if (w.command == CMD_SAMPLE)
        begin
            prod = w.adc_sample * p_scale;
            acc = longint'(p_pack) * bftl_pkg::OLD_WEIGHT
                + longint'(prod[35:16]) * bftl_pkg::NEW_WEIGHT;
            acc = acc / bftl_pkg::FILTER_DIV;
            p_pack = (acc > longint'(bftl_pkg::VOLT_MAX)) ? bftl_pkg::VOLT_MAX
                                                          : acc[VOLT_W-1:0];
            if (!p_known)
            begin
                if (p_primed < bftl_pkg::FILTER_DIV)
                    p_primed++;
                if (p_primed >= bftl_pkg::FILTER_DIV)
                begin
                    if (p_pack > p_three_floor)
                        p_cells = bftl_pkg::CELLS_THREE;
                    else if (p_pack > p_two_floor)
                        p_cells = bftl_pkg::CELLS_TWO;
                    else
                        p_cells = bftl_pkg::CELLS_ONE;
                    p_known = 1'b1;
                end
            end
        end
        else
        begin
            cellv = longint'(p_pack) / longint'(p_cells);
            lo = longint'(p_cutoff);
            hi = longint'(p_low_mark);
            dem = longint'(signed'(w.throttle_demand));
            flr = longint'(signed'(w.throttle_floor));
            if (lo > cellv)
                r = flr;
            else if (hi > cellv && w.stick_high)
                r = ((cellv - lo) * (dem - flr)) / (hi - lo) + flr;
            else
                r = dem;
            o.throttle_out = r[THR_W-1:0];
        end
        o.pack_voltage = p_pack;
        o.cell_count   = p_cells;
        o.cells_known  = p_known;
        return o;
    endfunction

    function automatic bftl_pkg::in_item_t sample_word(input int adc);
        bftl_pkg::in_item_t w;
        w.command         = CMD_SAMPLE;
        w.adc_sample      = adc[ADC_W-1:0];
        w.throttle_demand = THR_W'($urandom_range(16'hFFFF));
        w.stick_high      = 1'($urandom_range(1));
        w.throttle_floor  = THR_W'($urandom_range(16'hFFFF));
        return w;
    endfunction

    function automatic bftl_pkg::in_item_t request_word(
            input logic signed [THR_W-1:0] demand,
            input logic stick,
            input logic signed [THR_W-1:0] floor_thr);
        bftl_pkg::in_item_t w;
        w.command         = CMD_THROTTLE;
        w.adc_sample      = ADC_W'($urandom_range(4095));
        w.throttle_demand = demand;
        w.stick_high      = stick;
        w.throttle_floor  = floor_thr;
        return w;
    endfunction

    // Sample near mid-scale to hold the filter steady, with some full-range noise
    function automatic bftl_pkg::in_item_t steady_sample();
        if ($urandom_range(9) == 0)
            return sample_word(int'($urandom_range(4095)));
        return sample_word(2048 + int'($urandom_range(128)) - 64);
    endfunction

    function automatic bftl_pkg::in_item_t random_word();
        if ($urandom_range(99) < 30)
            return steady_sample();
        case ($urandom_range(7))
            0: return request_word(THR_MAX, 1'($urandom_range(1)), THR_MIN);
            1: return request_word(THR_MIN, 1'($urandom_range(1)), THR_MAX);
            default: return request_word(THR_W'($urandom_range(16'hFFFF)),
                                         1'($urandom_range(1)),
                                         THR_W'($urandom_range(16'hFFFF)));
        endcase
    endfunction

    function automatic int cell_now();
        longint c;
        c = longint'(p_pack) / longint'(p_cells);
        return (c > CELLV_MAX) ? CELLV_MAX : int'(c);
    endfunction

    task automatic send_word(input bftl_pkg::in_item_t w);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_readings.push_back(expected_reading(w));
        words_sent++;
    endtask

    // Drop valid, wait out every reading, then let the block settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input bftl_pkg::cfg_reg_t idx, input int unsigned value);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_wen <= 1'b0;
        @(posedge clk);
        case (idx)
            bftl_pkg::REG_VOLT_SCALE:  p_scale       = value[SCALE_W-1:0];
            bftl_pkg::REG_THREE_FLOOR: p_three_floor = value[VOLT_W-1:0];
            bftl_pkg::REG_TWO_FLOOR:   p_two_floor   = value[VOLT_W-1:0];
            bftl_pkg::REG_CELL_CUTOFF: p_cutoff      = value[CELLV_W-1:0];
            bftl_pkg::REG_CELL_LOW:    p_low_mark    = value[CELLV_W-1:0];
            default: ;
        endcase
    endtask

    // Before latching the count is one; floors chosen to force one of the outcomes
    task automatic test_power_on_requests();
        int mode;
        mode = $urandom_range(3);
        write_reg(bftl_pkg::REG_VOLT_SCALE, 32'(bftl_pkg::VOLT_SCALE_RST));
        write_reg(bftl_pkg::REG_THREE_FLOOR,
                  (mode == 0 || mode == 1) ? 32'(bftl_pkg::VOLT_MAX) : 0);
        write_reg(bftl_pkg::REG_TWO_FLOOR,
                  (mode == 0 || mode == 2) ? 32'(bftl_pkg::VOLT_MAX) : 0);
        write_reg(bftl_pkg::REG_CELL_CUTOFF, 32'(bftl_pkg::CUTOFF_RST));
        write_reg(bftl_pkg::REG_CELL_LOW, 32'(bftl_pkg::LOW_MARK_RST));
        send_word(request_word(THR_MAX, 1'b1, THR_MIN));
        send_word(request_word(THR_MIN, 1'b0, THR_MAX));
        send_word(request_word(16'sd0, 1'b1, 16'sd0));
    endtask

    // Prime the filter; keep samples small so a cell voltage fits the 16-bit marks
    task automatic test_cell_detection();
        int k;
        send_word(sample_word(4095));
        send_word(sample_word(0));
        send_word(sample_word(1));
        for (k = 3; k < bftl_pkg::FILTER_DIV; k++)
            send_word(sample_word(int'($urandom_range(500))));
        send_word(sample_word(int'($urandom_range(500))));
        drain();
    endtask

    task automatic test_limit_regions();
        int c;
        int cut;
        c = cell_now();
        write_reg(bftl_pkg::REG_CELL_CUTOFF, (c < CELLV_MAX) ? c + 1 : c);
        write_reg(bftl_pkg::REG_CELL_LOW, CELLV_MAX);
        send_word(request_word(16'sd1000, 1'b1, -16'sd1000));
        drain();
        cut = (c > 500) ? c - 500 : 0;
        write_reg(bftl_pkg::REG_CELL_CUTOFF, cut);
        write_reg(bftl_pkg::REG_CELL_LOW, (c + 500 > CELLV_MAX) ? CELLV_MAX : c + 500);
        send_word(request_word(THR_MAX, 1'b1, THR_MIN));
        send_word(request_word(THR_MIN, 1'b1, THR_MAX));
        send_word(request_word(THR_MAX, 1'b0, THR_MIN));
        drain();
        // Low mark equal to cutoff: scaling unreachable
        write_reg(bftl_pkg::REG_CELL_LOW, cut);
        send_word(request_word(THR_MAX, 1'b1, THR_MIN));
        drain();
    endtask

    task automatic test_output_backpressure();
        int k;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_request = 300;
        for (k = 0; k < 8; k++)
            send_word(random_word());
        drain();
    endtask

    task automatic test_random_traffic();
        int p;
        int k;
        int c;
        int span;
        int cut;
        int unsigned scale;
        for (p = 0; p < PHASES; p++)
        begin
            send_idle_pct = (p < 4) ? 7 : (p < 8) ? 56 : 0;
            recv_idle_pct = (p < 4) ? 56 : (p < 8) ? 7 : 0;
            if (p == 3)
                scale = 0;
            else if (p == 7)
                scale = 24'hFFFFFF;
            else
                scale = p_cells * $urandom_range(1_000_000, 1_600_000);
            write_reg(bftl_pkg::REG_VOLT_SCALE, scale);
            write_reg(bftl_pkg::REG_THREE_FLOOR, (p == 0) ? 32'(bftl_pkg::VOLT_MAX) :
                      (p == 2) ? 0 : $urandom_range(bftl_pkg::VOLT_MAX));
            write_reg(bftl_pkg::REG_TWO_FLOOR, (p == 0) ? 32'(bftl_pkg::VOLT_MAX) :
                      (p == 2) ? 0 : $urandom_range(bftl_pkg::VOLT_MAX));
            // Place the marks around the cell voltage the filter settles to
            c = int'(((longint'(2048) * scale) >> 16) / p_cells);
            if (c > CELLV_MAX)
                c = CELLV_MAX;
            span = $urandom_range(1, 8000);
            cut = c - int'($urandom_range(span));
            if (cut < 0)
                cut = 0;
            case (p)
                1:
                begin
                    write_reg(bftl_pkg::REG_CELL_CUTOFF, 0);
                    write_reg(bftl_pkg::REG_CELL_LOW, CELLV_MAX);
                end
                6:
                begin
                    write_reg(bftl_pkg::REG_CELL_CUTOFF, CELLV_MAX);
                    write_reg(bftl_pkg::REG_CELL_LOW, 0);
                end
                9:
                begin
                    write_reg(bftl_pkg::REG_CELL_CUTOFF, cut);
                    write_reg(bftl_pkg::REG_CELL_LOW, $urandom_range(cut));
                end
                default:
                begin
                    write_reg(bftl_pkg::REG_CELL_CUTOFF, cut);
                    write_reg(bftl_pkg::REG_CELL_LOW,
                              (cut + span > CELLV_MAX) ? CELLV_MAX : cut + span);
                end
            endcase
            for (k = 0; k < 32; k++)
                send_word(steady_sample());
            for (k = 0; k < 68; k++)
                send_word(random_word());
            drain();
        end
    endtask

    // Check each reading against the oldest expectation; hold off on request
    initial
    begin
        bftl_pkg::out_item_t exp;
        int stall_left;
        stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_readings.size() == 0)
                begin
                    $display("%0t: reading with none expected: %p", $time, out_data);
                    mismatch_count++;
                end
                else
                begin
                    exp = pending_readings.pop_front();
                    readings_checked++;
                    if (out_data.throttle_out !== exp.throttle_out)
                    begin
                        $display("%0t: throttle_out expected %0d got %0d", $time,
                                 exp.throttle_out, out_data.throttle_out);
                        mismatch_count++;
                    end
                    if (out_data.pack_voltage !== exp.pack_voltage)
                    begin
                        $display("%0t: pack_voltage expected %0d got %0d", $time,
                                 exp.pack_voltage, out_data.pack_voltage);
                        mismatch_count++;
                    end
                    if (out_data.cell_count !== exp.cell_count)
                    begin
                        $display("%0t: cell_count expected %0d got %0d", $time,
                                 exp.cell_count, out_data.cell_count);
                        mismatch_count++;
                    end
                    if (out_data.cells_known !== exp.cells_known)
                    begin
                        $display("%0t: cells_known expected %0d got %0d", $time,
                                 exp.cells_known, out_data.cells_known);
                        mismatch_count++;
                    end
                end
            end
            if (stall_request != 0)
            begin
                stall_left = stall_request;
                stall_request = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        mismatch_count   = 0;
        words_sent       = 0;
        readings_checked = 0;
        send_idle_pct    = 7;
        recv_idle_pct    = 56;
        stall_request    = 0;
        p_scale       = bftl_pkg::VOLT_SCALE_RST;
        p_three_floor = bftl_pkg::THREE_FLOOR_RST;
        p_two_floor   = bftl_pkg::TWO_FLOOR_RST;
        p_cutoff      = bftl_pkg::CUTOFF_RST;
        p_low_mark    = bftl_pkg::LOW_MARK_RST;
        p_pack        = bftl_pkg::FILTERED_RST;
        p_primed      = 0;
        p_cells       = bftl_pkg::CELLS_ONE;
        p_known       = 1'b0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_wen   <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on_requests();
        test_cell_detection();
        test_limit_regions();
        test_output_backpressure();
        test_random_traffic();
        drain();

        $display("Run covered %0d words and %0d readings over %0d register settings;",
                 words_sent, readings_checked, PHASES + 4);
        $display("cell count latched at %0d, idle on both sides and one long receiver hold-off.",
                 p_cells);
        if (mismatch_count == 0 && pending_readings.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
